// ===== rtl/core/bic3_pkg.sv =====
// Shared types and constants for the binary 3x3 image filter.
`timescale 1ns / 1ps

package bic3_pkg;

    // Field and register widths
    localparam int KERNEL_W   = 9;
    localparam int FWIDTH_W   = 11;
    localparam int FHEIGHT_W  = 16;
    localparam int SUM_W      = 4;
    localparam int ROW_W      = 16;
    localparam int CFG_DATA_W = 16;
    localparam int CFG_IDX_W  = 2;

    // Register reset values
    localparam logic [KERNEL_W-1:0]  KERNEL_RESET  = 9'd341;
    localparam logic [FWIDTH_W-1:0]  FWIDTH_RESET  = 11'd1024;
    localparam logic [FHEIGHT_W-1:0] FHEIGHT_RESET = 16'd1024;

    // Smallest legal frame edge
    localparam int MIN_EDGE = 3;

    // Configuration register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_KERNEL_MASK  = 2'd0,
        CFG_FRAME_WIDTH  = 2'd1,
        CFG_FRAME_HEIGHT = 2'd2
    } t_cfg_index;

endpackage

// ===== rtl/core/binary_image_conv3x3_core.sv =====
// Binary 3x3 masked-sum filter over a raster pixel stream, with two line stores.
// An accepted pixel's result is registered in stage 1, then in the output register.
// Throughput: 1 pixel per cycle unless stalled; one line store read and write at most.
// Reset: synchronous active low; clears counters, window, valid flags and restores
// kernel mask 341 and a 1024 x 1024 frame. Line store contents are not cleared.
`timescale 1ns / 1ps

module binary_image_conv3x3_core
    import bic3_pkg::*;
#(
    parameter int MAX_WIDTH = 1024
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    // configuration write port
    input  logic                  i_cfg_wr_en,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    // pixel channel
    input  logic                  i_pixel_valid,
    output logic                  o_pixel_stall,
    input  logic                  i_pixel,
    // result channel
    output logic                  o_result_valid,
    input  logic                  i_result_stall,
    output logic [SUM_W-1:0]      o_filtered,
    output logic [ROW_W-1:0]      o_out_row,
    output logic [$clog2(MAX_WIDTH)-1:0] o_out_col,
    output logic                  o_frame_last
);

    localparam int COL_W = $clog2(MAX_WIDTH);
    localparam int EW    = (COL_W + 1 > FWIDTH_W) ? COL_W + 1 : FWIDTH_W;
    localparam int RESET_WIDTH = (int'(FWIDTH_RESET) > MAX_WIDTH) ? MAX_WIDTH
                                                                  : int'(FWIDTH_RESET);
    localparam logic [COL_W-1:0] COL_LAST_RESET = COL_W'(RESET_WIDTH - 1);
    localparam logic [ROW_W-1:0] ROW_LAST_RESET = ROW_W'(int'(FHEIGHT_RESET) - 1);

    // Line store: bit 1 holds row r-2, bit 0 holds row r-1
    logic [1:0]            r_mem [MAX_WIDTH];
    logic [1:0]            r_rd;

    // Configuration state
    logic [KERNEL_W-1:0]   r_kernel;
    logic [COL_W-1:0]      r_col_last;
    logic [ROW_W-1:0]      r_row_last;

    // Raster position
    logic [COL_W-1:0]      r_col;
    logic [ROW_W-1:0]      r_row;

    // Stage 1
    logic                  r_s1_valid;
    logic                  r_s1_pixel;
    logic [COL_W-1:0]      r_s1_col;
    logic [ROW_W-1:0]      r_s1_row;
    logic                  r_s1_emit;
    logic                  r_s1_last;

    // Window and output register
    logic [KERNEL_W-1:0]   r_window;
    logic [KERNEL_W-1:0]   n_window;
    logic [SUM_W-1:0]      n_sum;
    logic                  r_out_valid;
    logic [SUM_W-1:0]      r_out_sum;
    logic [ROW_W-1:0]      r_out_row;
    logic [COL_W-1:0]      r_out_col;
    logic                  r_out_last;

    logic                  w_adv;
    logic                  w_accept;
    logic                  w_geom_wr;
    logic [COL_W-1:0]      n_col_last;
    logic [ROW_W-1:0]      n_row_last;
    logic [EW-1:0]         w_fw_ext;
    logic [EW-1:0]         w_fw_eff;
    logic [FHEIGHT_W-1:0]  w_fh_eff;

    // Pipeline moves whenever the output register can take a transaction
    assign w_adv         = !(r_out_valid && i_result_stall);
    assign o_pixel_stall = !w_adv;
    assign w_accept      = i_pixel_valid && w_adv;

    // Clamp the geometry on write
    always_comb begin
        w_fw_ext = EW'(i_cfg_data[FWIDTH_W-1:0]);
        if (w_fw_ext < EW'(MIN_EDGE)) begin
            w_fw_eff = EW'(MIN_EDGE);
        end else if (w_fw_ext > EW'(MAX_WIDTH)) begin
            w_fw_eff = EW'(MAX_WIDTH);
        end else begin
            w_fw_eff = w_fw_ext;
        end
        n_col_last = COL_W'(w_fw_eff - EW'(1));

        if (i_cfg_data[FHEIGHT_W-1:0] < FHEIGHT_W'(MIN_EDGE)) begin
            w_fh_eff = FHEIGHT_W'(MIN_EDGE);
        end else begin
            w_fh_eff = i_cfg_data[FHEIGHT_W-1:0];
        end
        n_row_last = w_fh_eff - ROW_W'(1);
    end

    assign w_geom_wr = i_cfg_wr_en &&
                       ((i_cfg_index == CFG_FRAME_WIDTH) || (i_cfg_index == CFG_FRAME_HEIGHT));

    // Decode configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kernel   <= KERNEL_RESET;
            r_col_last <= COL_LAST_RESET;
            r_row_last <= ROW_LAST_RESET;
        end else if (i_cfg_wr_en) begin
            unique case (t_cfg_index'(i_cfg_index))
                CFG_KERNEL_MASK:  r_kernel   <= i_cfg_data[KERNEL_W-1:0];
                CFG_FRAME_WIDTH:  r_col_last <= n_col_last;
                CFG_FRAME_HEIGHT: r_row_last <= n_row_last;
                default: begin
                end
            endcase
        end
    end

    // Advance the raster position; restart on a geometry write
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_geom_wr) begin
            r_col <= '0;
            r_row <= '0;
        end else if (w_accept) begin
            if (r_col == r_col_last) begin
                r_col <= '0;
                r_row <= (r_row == r_row_last) ? '0 : r_row + ROW_W'(1);
            end else begin
                r_col <= r_col + COL_W'(1);
            end
        end
    end

    // Line store: read at accept, write back one stage later
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_rd <= r_mem[r_col];
        end
        if (w_adv && r_s1_valid) begin
            r_mem[r_s1_col] <= {r_rd[0], r_s1_pixel};
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (w_adv) begin
            r_s1_valid <= w_accept;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_s1_pixel <= i_pixel;
            r_s1_col   <= r_col;
            r_s1_row   <= r_row;
            r_s1_emit  <= (r_row >= ROW_W'(2)) && (r_col >= COL_W'(2));
            r_s1_last  <= (r_row == r_row_last) && (r_col == r_col_last);
        end
    end

    // Shift in the new column and count masked ones
    always_comb begin
        n_window = {r_s1_pixel, r_window[8:7], r_rd[0], r_window[5:4], r_rd[1], r_window[2:1]};
        n_sum    = '0;
        for (int k = 0; k < KERNEL_W; k++) begin
            n_sum = n_sum + SUM_W'(n_window[k] & r_kernel[k]);
        end
    end

    // Hold the window
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || w_geom_wr) begin
            r_window <= '0;
        end else if (w_adv && r_s1_valid) begin
            r_window <= n_window;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= r_s1_valid && r_s1_emit;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (w_adv && r_s1_valid && r_s1_emit) begin
            r_out_sum  <= n_sum;
            r_out_row  <= r_s1_row - ROW_W'(1);
            r_out_col  <= r_s1_col - COL_W'(1);
            r_out_last <= r_s1_last;
        end
    end

    assign o_result_valid = r_out_valid;
    assign o_filtered     = r_out_sum;
    assign o_out_row      = r_out_row;
    assign o_out_col      = r_out_col;
    assign o_frame_last   = r_out_last;

endmodule
